FILE: rtl/blsp_pkg.sv
// Types and constants for the line stepper: request, response and queued command words.
// Used by every module of the block. No dependencies.
`default_nettype none

package blsp_pkg;

   localparam int COORD_BITS  = 16;
   localparam int DELTA_BITS  = COORD_BITS + 1;
   localparam int ERROR_BITS  = COORD_BITS + 3;
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [0:0] {
      KIND_LOAD = 1'b0,
      KIND_STEP = 1'b1
   } kind_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [DELTA_BITS-1:0]        delta_type;
   typedef logic signed [ERROR_BITS-1:0] error_type;

   typedef struct packed {
      kind_type  kind;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
   } req_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      logic      last;
   } rsp_type;

   typedef struct packed {
      kind_type  kind;
      logic      steep;
      logic      minor_down;
      coord_type major_pos;
      coord_type major_stop;
      coord_type minor_pos;
      delta_type major_delta;
      delta_type minor_delta;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic emit;
      logic fin;
   } back_stat_type;

endpackage

`default_nettype wire

FILE: rtl/blsp_front.sv
// Front end: classifies a request word and sets up a line (axis swap, ordering, deltas).
// Depends on blsp_pkg.
`default_nettype none

module blsp_front (
   input  blsp_pkg::req_type req_word,
   output blsp_pkg::cmd_type cmd_word
);

   localparam int DB = blsp_pkg::DELTA_BITS;

   logic signed [DB-1:0] dx;
   logic signed [DB-1:0] dy;
   logic signed [DB-1:0] da;
   logic signed [DB-1:0] db;
   blsp_pkg::delta_type  adx;
   blsp_pkg::delta_type  ady;
   blsp_pkg::coord_type  a0;
   blsp_pkg::coord_type  a1;
   blsp_pkg::coord_type  b0;
   blsp_pkg::coord_type  b1;
   logic                 steep;
   logic                 order;
   logic                 db_pos;
   logic                 db_neg;

   always_comb begin
      dx = DB'(req_word.x_end) - DB'(req_word.x_start);
      dy = DB'(req_word.y_end) - DB'(req_word.y_start);
      adx = dx[DB-1] ? blsp_pkg::delta_type'(-dx) : blsp_pkg::delta_type'(dx);
      ady = dy[DB-1] ? blsp_pkg::delta_type'(-dy) : blsp_pkg::delta_type'(dy);
      steep = ady > adx;

      a0 = steep ? req_word.y_start : req_word.x_start;
      a1 = steep ? req_word.y_end   : req_word.x_end;
      b0 = steep ? req_word.x_start : req_word.y_start;
      b1 = steep ? req_word.x_end   : req_word.y_end;
      da = steep ? dy : dx;
      db = steep ? dx : dy;

      order  = da[DB-1];
      db_neg = db[DB-1];
      db_pos = !db[DB-1] && (db != '0);

      cmd_word.kind        = req_word.kind;
      cmd_word.steep       = steep;
      cmd_word.major_pos   = order ? a1 : a0;
      cmd_word.major_stop  = order ? a0 : a1;
      cmd_word.minor_pos   = order ? b1 : b0;
      cmd_word.major_delta = steep ? ady : adx;
      cmd_word.minor_delta = steep ? adx : ady;
      cmd_word.minor_down  = order ? !db_neg : !db_pos;
   end

endmodule

`default_nettype wire

FILE: rtl/blsp_queue.sv
// Short shift queue of command words between front and back end.
// Depends on blsp_pkg.
`default_nettype none

module blsp_queue #(
   parameter int DEPTH = blsp_pkg::QUEUE_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   output logic              in_stall,
   input  blsp_pkg::cmd_type in_word,
   output logic              out_valid,
   input  wire               out_stall,
   output blsp_pkg::cmd_type out_word
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   blsp_pkg::cmd_type   slot_ff [DEPTH];
   blsp_pkg::cmd_type   slot_in [DEPTH];
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic [CNT_BITS-1:0] wr_idx;
   logic                push;
   logic                pop;

   assign in_stall  = (count_ff == CNT_BITS'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_word  = slot_ff[0];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_idx   = count_ff - CNT_BITS'(pop);
      count_in = count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
      for (int i = 0; i < DEPTH - 1; i++) begin
         slot_in[i] = pop ? slot_ff[i+1] : slot_ff[i];
      end
      slot_in[DEPTH-1] = slot_ff[DEPTH-1];
      for (int i = 0; i < DEPTH; i++) begin
         if (push && (wr_idx == CNT_BITS'(i))) begin
            slot_in[i] = in_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/blsp_back.sv
// Back end: holds the active line, steps a pixel per step command, registers the response word.
// Depends on blsp_pkg.
`default_nettype none

module blsp_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      cmd_valid,
   output logic                     cmd_stall,
   input  blsp_pkg::cmd_type        cmd_word,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output blsp_pkg::rsp_type        rsp_word,
   output blsp_pkg::back_stat_type  stat
);

   localparam int EB = blsp_pkg::ERROR_BITS;
   localparam blsp_pkg::coord_type COORD_ONE = blsp_pkg::coord_type'(1);

   logic                 active_ff,     active_in;
   logic                 steep_ff,      steep_in;
   logic                 minor_down_ff, minor_down_in;
   blsp_pkg::coord_type  major_pos_ff,  major_pos_in;
   blsp_pkg::coord_type  major_stop_ff, major_stop_in;
   blsp_pkg::coord_type  minor_pos_ff,  minor_pos_in;
   blsp_pkg::delta_type  major_delta_ff, major_delta_in;
   blsp_pkg::delta_type  minor_delta_ff, minor_delta_in;
   blsp_pkg::error_type  error_ff,      error_in;
   logic                 rsp_valid_ff,  rsp_valid_in;
   blsp_pkg::rsp_type    rsp_word_ff,   rsp_word_in;

   logic                 need_out;
   logic                 take;
   logic                 emit;
   logic                 fin;
   blsp_pkg::error_type  err_sum;
   logic signed [EB:0]   twice_sum;
   logic                 minor_move;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      need_out  = (cmd_word.kind == blsp_pkg::KIND_STEP) && active_ff;
      cmd_stall = need_out && rsp_valid_ff && rsp_stall;
      take      = cmd_valid && !cmd_stall;
      emit      = take && need_out;
      fin       = (major_pos_ff >= major_stop_ff);

      err_sum    = error_ff + EB'(minor_delta_ff);
      twice_sum  = {err_sum, 1'b0};
      minor_move = (twice_sum >= $signed({2'b00, major_delta_ff}));

      active_in      = active_ff;
      steep_in       = steep_ff;
      minor_down_in  = minor_down_ff;
      major_pos_in   = major_pos_ff;
      major_stop_in  = major_stop_ff;
      minor_pos_in   = minor_pos_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      error_in       = error_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;

      if (take && (cmd_word.kind == blsp_pkg::KIND_LOAD)) begin
         active_in      = 1'b1;
         steep_in       = cmd_word.steep;
         minor_down_in  = cmd_word.minor_down;
         major_pos_in   = cmd_word.major_pos;
         major_stop_in  = cmd_word.major_stop;
         minor_pos_in   = cmd_word.minor_pos;
         major_delta_in = cmd_word.major_delta;
         minor_delta_in = cmd_word.minor_delta;
         error_in       = '0;
      end else if (emit) begin
         rsp_valid_in        = 1'b1;
         rsp_word_in.point_x = steep_ff ? minor_pos_ff : major_pos_ff;
         rsp_word_in.point_y = steep_ff ? major_pos_ff : minor_pos_ff;
         rsp_word_in.last    = fin;
         if (fin) begin
            active_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + COORD_ONE;
            if (minor_move) begin
               error_in     = err_sum - EB'(major_delta_ff);
               minor_pos_in = minor_down_ff ? minor_pos_ff - COORD_ONE
                                            : minor_pos_ff + COORD_ONE;
            end else begin
               error_in = err_sum;
            end
         end
      end

      stat.active = active_ff;
      stat.emit   = emit;
      stat.fin    = fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         steep_ff       <= 1'b0;
         minor_down_ff  <= 1'b0;
         major_pos_ff   <= '0;
         major_stop_ff  <= '0;
         minor_pos_ff   <= '0;
         major_delta_ff <= '0;
         minor_delta_ff <= '0;
         error_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         active_ff      <= active_in;
         steep_ff       <= steep_in;
         minor_down_ff  <= minor_down_in;
         major_pos_ff   <= major_pos_in;
         major_stop_ff  <= major_stop_in;
         minor_pos_ff   <= minor_pos_in;
         major_delta_ff <= major_delta_in;
         minor_delta_ff <= minor_delta_in;
         error_ff       <= error_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

endmodule

`default_nettype wire

FILE: rtl/bresenham_line_stepper.sv
// Bresenham line stepper top level: front end, command queue and stepping back end.
// Depends on blsp_pkg, blsp_front, blsp_queue and blsp_back.
//
//   channel   direction  word type           handshake
//   req_      in         blsp_pkg::req_type  req_valid / req_stall
//   rsp_      out        blsp_pkg::rsp_type  rsp_valid / rsp_stall
//
// One request word per cycle while req_stall is low; a step word leaves as a response
// through a queue slot, then the response register. The back end takes one command a
// cycle unless a held response stalls it: one error add, one compare and a select.
// req_stall rises only when the queue holds QUEUE_DEPTH words behind a stalled response.
// Synchronous reset clears the queue, the line state and the response valid.
`default_nettype none

module bresenham_line_stepper #(
   parameter int QUEUE_DEPTH = blsp_pkg::QUEUE_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  blsp_pkg::req_type req_word,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output blsp_pkg::rsp_type rsp_word
);

   blsp_pkg::cmd_type       front_word;
   blsp_pkg::cmd_type       q_word;
   logic                    q_valid;
   logic                    q_stall;
   blsp_pkg::back_stat_type back_stat;

   blsp_front u_front (
      .req_word (req_word),
      .cmd_word (front_word)
   );

   blsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_word   (front_word),
      .out_valid (q_valid),
      .out_stall (q_stall),
      .out_word  (q_word)
   );

   blsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_stall (q_stall),
      .cmd_word  (q_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .stat      (back_stat)
   );

`ifndef ASSERT_OFF
   a_load_activates : assert property (@(posedge clock) disable iff (reset)
      (q_valid && !q_stall && (q_word.kind == blsp_pkg::KIND_LOAD)) |=> back_stat.active)
      else $error("line not active after load");

   a_last_idles : assert property (@(posedge clock) disable iff (reset)
      (back_stat.emit && back_stat.fin) |=> !back_stat.active)
      else $error("line still active after last pixel");

   a_rsp_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(back_stat.emit))
      else $error("response without a step");
`endif

endmodule

`default_nettype wire

FILE: verif/bresenham_line_stepper_tb.sv
// Self-checking testbench for bresenham_line_stepper: a directed table, then random lines,
// with every pixel word compared against its pinned value or an in-bench line tracer.
// Depends on blsp_pkg and the bresenham_line_stepper RTL.
`default_nettype none

module bresenham_line_stepper_tb;

   typedef struct packed {
      logic              pinned;
      logic              has_rsp;
      blsp_pkg::rsp_type rsp;
   } pixel_pin_type;

   typedef struct packed {
      blsp_pkg::req_type word;
      pixel_pin_type     pin;
   } plan_row_type;

   typedef struct {
      bit                  active;
      bit                  steep;
      bit                  minor_down;
      blsp_pkg::coord_type major_pos;
      blsp_pkg::coord_type major_stop;
      blsp_pkg::coord_type minor_pos;
      blsp_pkg::delta_type major_delta;
      blsp_pkg::delta_type minor_delta;
      blsp_pkg::error_type err;
   } line_trace_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   blsp_pkg::req_type req_word  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   blsp_pkg::rsp_type rsp_word;

   line_trace_type    line_now = '{default: '0};
   blsp_pkg::rsp_type pixel_q[$];
   pixel_pin_type     pin_q[$];
   plan_row_type      plan_q[$];

   int errors        = 0;
   int req_seen      = 0;
   int rsp_seen      = 0;
   int quiet_cycles  = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   bresenham_line_stepper u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int iabs(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // Advance the line tracer by one request word; returns 1 when a pixel is due.
   function automatic bit trace_pixel(input blsp_pkg::req_type w,
                                      output blsp_pkg::rsp_type px);
      int a0, b0, a1, b1, t, acc;
      bit steep, fin;
      px = '0;
      if (w.kind == blsp_pkg::KIND_LOAD) begin
         a0 = w.x_start;
         b0 = w.y_start;
         a1 = w.x_end;
         b1 = w.y_end;
         steep = iabs(b1 - b0) > iabs(a1 - a0);
         if (steep) begin
            t = a0; a0 = b0; b0 = t;
            t = a1; a1 = b1; b1 = t;
         end
         if (a0 > a1) begin
            t = a0; a0 = a1; a1 = t;
            t = b0; b0 = b1; b1 = t;
         end
         line_now.active      = 1'b1;
         line_now.steep       = steep;
         line_now.minor_down  = !(b0 < b1);
         line_now.major_pos   = blsp_pkg::coord_type'(a0);
         line_now.major_stop  = blsp_pkg::coord_type'(a1);
         line_now.minor_pos   = blsp_pkg::coord_type'(b0);
         line_now.major_delta = blsp_pkg::delta_type'(a1 - a0);
         line_now.minor_delta = blsp_pkg::delta_type'(iabs(b1 - b0));
         line_now.err         = '0;
         return 1'b0;
      end
      if (!line_now.active)
         return 1'b0;
      px.point_x = line_now.steep ? line_now.minor_pos : line_now.major_pos;
      px.point_y = line_now.steep ? line_now.major_pos : line_now.minor_pos;
      fin        = line_now.major_pos >= line_now.major_stop;
      px.last    = fin;
      if (fin) begin
         line_now.active = 1'b0;
      end else begin
         acc = int'(line_now.err) + int'(line_now.minor_delta);
         if (2 * acc >= int'(line_now.major_delta)) begin
            line_now.minor_pos = blsp_pkg::coord_type'(int'(line_now.minor_pos)
                                             + (line_now.minor_down ? -1 : 1));
            acc = acc - int'(line_now.major_delta);
         end
         line_now.err       = blsp_pkg::error_type'(acc);
         line_now.major_pos = blsp_pkg::coord_type'(int'(line_now.major_pos) + 1);
      end
      return 1'b1;
   endfunction

   function automatic blsp_pkg::req_type make_load(input int x0, input int y0,
                                                   input int x1, input int y1);
      blsp_pkg::req_type w;
      w.kind    = blsp_pkg::KIND_LOAD;
      w.x_start = blsp_pkg::coord_type'(x0);
      w.y_start = blsp_pkg::coord_type'(y0);
      w.x_end   = blsp_pkg::coord_type'(x1);
      w.y_end   = blsp_pkg::coord_type'(y1);
      return w;
   endfunction

   function automatic blsp_pkg::req_type make_step();
      blsp_pkg::req_type w;
      w.kind    = blsp_pkg::KIND_STEP;
      w.x_start = blsp_pkg::coord_type'($urandom);
      w.y_start = blsp_pkg::coord_type'($urandom);
      w.x_end   = blsp_pkg::coord_type'($urandom);
      w.y_end   = blsp_pkg::coord_type'($urandom);
      return w;
   endfunction

   function automatic plan_row_type load_row(input int x0, input int y0,
                                             input int x1, input int y1);
      plan_row_type r;
      r.word = make_load(x0, y0, x1, y1);
      r.pin  = '{pinned: 1'b1, has_rsp: 1'b0, rsp: '0};
      return r;
   endfunction

   function automatic plan_row_type step_row(input bit pinned, input bit has_rsp,
                                             input int px, input int py, input bit fin);
      plan_row_type r;
      r.word.kind    = blsp_pkg::KIND_STEP;
      r.word.x_start = '1;
      r.word.y_start = '1;
      r.word.x_end   = '1;
      r.word.y_end   = '1;
      r.pin.pinned   = pinned;
      r.pin.has_rsp  = has_rsp;
      r.pin.rsp      = '{point_x: blsp_pkg::coord_type'(px),
                         point_y: blsp_pkg::coord_type'(py), last: fin};
      return r;
   endfunction

   function automatic void add_row(input plan_row_type r);
      plan_q.insert(plan_q.size(), r);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   task automatic send_word(input blsp_pkg::req_type w, input pixel_pin_type p);
      int gap = 0;
      while (hold_left == 0 && gap < 40 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pin_q.insert(pin_q.size(), p);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served < hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left   <= 80;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      blsp_pkg::rsp_type want, pred;
      pixel_pin_type     pin;
      bit                has;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (pixel_q.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                               rsp_word.point_x, rsp_word.point_y, rsp_word.last));
            end else begin
               want = pixel_q.pop_front();
               if (rsp_word.point_x !== want.point_x)
                  report_mismatch($sformatf("point_x %0d, want %0d",
                                  rsp_word.point_x, want.point_x));
               if (rsp_word.point_y !== want.point_y)
                  report_mismatch($sformatf("point_y %0d, want %0d",
                                  rsp_word.point_y, want.point_y));
               if (rsp_word.last !== want.last)
                  report_mismatch($sformatf("last %0b, want %0b", rsp_word.last, want.last));
            end
         end
         if (req_valid && !req_stall) begin
            req_seen++;
            pin = pin_q.pop_front();
            has = trace_pixel(req_word, pred);
            if (pin.pinned) begin
               if (pin.has_rsp)
                  pixel_q.insert(pixel_q.size(), pin.rsp);
            end else if (has) begin
               pixel_q.insert(pixel_q.size(), pred);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 4000) begin
         $display("FAIL bresenham_line_stepper");
         $finish;
      end
   end

   initial begin : stimulus
      pixel_pin_type free_pin;
      int items, phase, ph, r, x0, y0, x1, y1, dx, dy, len, steps;
      free_pin = '{pinned: 1'b0, has_rsp: 1'b0, rsp: '0};
      items    = 0;
      phase    = -1;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // advance while idle, single point, then idle again
      add_row(step_row(1'b1, 1'b0, 0, 0, 1'b0));
      add_row(load_row(0, 0, 0, 0));
      add_row(step_row(1'b1, 1'b1, 0, 0, 1'b1));
      add_row(step_row(1'b1, 1'b0, 0, 0, 1'b0));
      // full-range diagonal, equal deltas so x is major
      add_row(load_row(-32768, -32768, 32767, 32767));
      add_row(step_row(1'b1, 1'b1, -32768, -32768, 1'b0));
      add_row(step_row(1'b1, 1'b1, -32767, -32767, 1'b0));
      // replace mid-line, reversed endpoints, minor descending
      add_row(load_row(32767, -32768, -32768, 32767));
      add_row(step_row(1'b1, 1'b1, -32768, 32767, 1'b0));
      add_row(step_row(1'b1, 1'b1, -32767, 32766, 1'b0));
      // steep full-range vertical
      add_row(load_row(5, -32768, 5, 32767));
      add_row(step_row(1'b1, 1'b1, 5, -32768, 1'b0));
      // short reversed horizontal, run to the end and past it
      add_row(load_row(100, 7, 97, 7));
      add_row(step_row(1'b1, 1'b1, 97, 7, 1'b0));
      add_row(step_row(1'b1, 1'b1, 98, 7, 1'b0));
      add_row(step_row(1'b1, 1'b1, 99, 7, 1'b0));
      add_row(step_row(1'b1, 1'b1, 100, 7, 1'b1));
      add_row(step_row(1'b1, 1'b0, 0, 0, 1'b0));
      // steep short line, traced
      add_row(load_row(0, 0, 2, 5));
      repeat (5) add_row(step_row(1'b0, 1'b0, 0, 0, 1'b0));

      send_idle_pct = 30;
      stall_pct     = 30;
      foreach (plan_q[i])
         send_word(plan_q[i].word, plan_q[i].pin);

      while (items < 1400) begin
         ph = items * 4 / 1400;
         if (ph != phase) begin
            phase = ph;
            case (ph)
               0: begin send_idle_pct = 0;  stall_pct = 0;  end
               1: begin send_idle_pct = 62; stall_pct = 0;  end
               2: begin send_idle_pct = 0;  stall_pct = 62; end
               default: begin send_idle_pct = 38; stall_pct = 38; end
            endcase
            if (ph == 0 || ph == 2)
               hold_requests++;
         end
         r = $urandom_range(99);
         if (r < 8) begin
            send_word(make_step(), free_pin);
            items++;
         end else if (r < 18) begin
            send_word(make_load(int'($urandom_range(65535)) - 32768,
                                int'($urandom_range(65535)) - 32768,
                                int'($urandom_range(65535)) - 32768,
                                int'($urandom_range(65535)) - 32768), free_pin);
            steps = $urandom_range(1, 6);
            repeat (steps) send_word(make_step(), free_pin);
            items += 1 + steps;
         end else begin
            x0 = int'($urandom_range(65535)) - 32768;
            y0 = int'($urandom_range(65535)) - 32768;
            dx = $urandom_range(0, 24) * ($urandom_range(1) ? 1 : -1);
            dy = $urandom_range(0, 24) * ($urandom_range(1) ? 1 : -1);
            x1 = (x0 + dx > 32767 || x0 + dx < -32768) ? x0 - dx : x0 + dx;
            y1 = (y0 + dy > 32767 || y0 + dy < -32768) ? y0 - dy : y0 + dy;
            len = (iabs(dx) > iabs(dy)) ? iabs(dx) : iabs(dy);
            r = $urandom_range(99);
            if (r < 15)
               steps = $urandom_range(0, len);
            else if (r >= 90)
               steps = len + 1 + $urandom_range(1, 2);
            else
               steps = len + 1;
            send_word(make_load(x0, y0, x1, y1), free_pin);
            repeat (steps) send_word(make_step(), free_pin);
            items += 1 + steps;
         end
      end

      req_valid <= 1'b0;
      while (pixel_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (pixel_q.size() != 0)
         report_mismatch($sformatf("%0d pixels never arrived", pixel_q.size()));

      $display("Run covered %0d request words and %0d pixel words over four idling phases,",
               req_seen, rsp_seen);
      $display("with two long output hold-offs and %0d mismatches.", errors);
      if (errors == 0)
         $display("PASS bresenham_line_stepper");
      else
         $display("FAIL bresenham_line_stepper");
      $finish;
   end

endmodule

`default_nettype wire
